[src/bfm_pkg.sv]
// Shared types, constants and arithmetic helpers for the butterfly rotation mixer.
`default_nettype none
package bfm_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_CH      = 8;
	localparam int NUM_STAGES  = 3;
	localparam int COEF_BITS   = 16;
	localparam int COEF_FRAC   = 15;

	// Butterfly stages that fit into CHANNELS: floor(log2(CHANNELS)).
	localparam int STAGES = $clog2(CHANNELS + 1) - 1;
	// Each stage is a product level followed by a sum level.
	localparam int LEVELS = 2 * STAGES;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int SUM_W  = PROD_W + 1;
	localparam int SHR_W  = SUM_W - COEF_FRAC;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [SUM_W-1:0]       sum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_S0_SINE   = 3'd0,
		CFG_S0_COSINE = 3'd1,
		CFG_S1_SINE   = 3'd2,
		CFG_S1_COSINE = 3'd3,
		CFG_S2_SINE   = 3'd4,
		CFG_S2_COSINE = 3'd5,
		CFG_REFLECT   = 3'd6
	} cfg_index_t;

	localparam coef_t COEF_RESET = coef_t'(23170);

	// Round half up by 2^COEF_FRAC, then clamp to the sample range.
	function automatic sample_t round_sat(input sum_t acc);
		logic signed [SUM_W-1:0] rnd;
		logic signed [SHR_W-1:0] q;
		sample_t res;
		rnd = acc + sum_t'(1 << (COEF_FRAC - 1));
		q   = SHR_W'(rnd >>> COEF_FRAC);
		if (q > SHR_W'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
			res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (q < SHR_W'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
			res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res = q[SAMPLE_BITS-1:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[src/bfm_in_if.sv]
// Input frame channel: valid, ready and eight channel samples.
`default_nettype none
interface bfm_in_if import bfm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t in_ch0;
	sample_t in_ch1;
	sample_t in_ch2;
	sample_t in_ch3;
	sample_t in_ch4;
	sample_t in_ch5;
	sample_t in_ch6;
	sample_t in_ch7;

	modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6,
		in_ch7, input ready);
	modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6,
		in_ch7, output ready);
endinterface
`default_nettype wire

[src/bfm_out_if.sv]
// Output frame channel: valid, ready and eight mixed samples.
`default_nettype none
interface bfm_out_if import bfm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t out_ch0;
	sample_t out_ch1;
	sample_t out_ch2;
	sample_t out_ch3;
	sample_t out_ch4;
	sample_t out_ch5;
	sample_t out_ch6;
	sample_t out_ch7;

	modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
		out_ch6, out_ch7, input ready);
	modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
		out_ch6, out_ch7, output ready);
endinterface
`default_nettype wire

[src/bfm_cfg_if.sv]
// Configuration write channel: valid, ready, register index and data.
`default_nettype none
interface bfm_cfg_if import bfm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/butterfly_rotation_matrix_mix_unit.sv]
// Each butterfly stage has a product level, then a sum level; both are registered.
// Throughput: one item per cycle while the output is not stalled.
// A level moves on when it is empty or the level after it moves, so bubbles close up.
// Reset clears all valid flags, sets every sine and cosine to 23170 and the reflect
// mask to zero. Configuration writes are always taken.
`default_nettype none
module butterfly_rotation_matrix_mix_unit import bfm_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	bfm_in_if.sink    frame_in,
	bfm_out_if.source frame_out,
	bfm_cfg_if.sink   cfg
);

	coef_t                 sine_q   [NUM_STAGES];
	coef_t                 cosine_q [NUM_STAGES];
	logic [NUM_STAGES-1:0] refl_q;

	logic [LEVELS-1:0] vld_q;
	logic [LEVELS:0]   en;

	sample_t raw [MAX_CH];
	sample_t ch  [STAGES+1][MAX_CH];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STAGES; s++) begin
				sine_q[s]   <= COEF_RESET;
				cosine_q[s] <= COEF_RESET;
			end
			refl_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_index_t'(cfg.index))
				CFG_S0_SINE:   sine_q[0]   <= coef_t'(cfg.data);
				CFG_S0_COSINE: cosine_q[0] <= coef_t'(cfg.data);
				CFG_S1_SINE:   sine_q[1]   <= coef_t'(cfg.data);
				CFG_S1_COSINE: cosine_q[1] <= coef_t'(cfg.data);
				CFG_S2_SINE:   sine_q[2]   <= coef_t'(cfg.data);
				CFG_S2_COSINE: cosine_q[2] <= coef_t'(cfg.data);
				CFG_REFLECT:   refl_q      <= cfg.data[NUM_STAGES-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Per-level advance: a level loads when it is empty or its contents move on.
	always_comb begin
		en[LEVELS] = frame_out.ready;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= frame_in.valid;
			end
			for (int k = 1; k < LEVELS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign frame_in.ready  = en[0];
	assign frame_out.valid = vld_q[LEVELS-1];

	assign raw[0] = frame_in.in_ch0;
	assign raw[1] = frame_in.in_ch1;
	assign raw[2] = frame_in.in_ch2;
	assign raw[3] = frame_in.in_ch3;
	assign raw[4] = frame_in.in_ch4;
	assign raw[5] = frame_in.in_ch5;
	assign raw[6] = frame_in.in_ch6;
	assign raw[7] = frame_in.in_ch7;

	for (genvar i = 0; i < MAX_CH; i++) begin : g_in
		assign ch[0][i] = (i < CHANNELS) ? raw[i] : '0;
	end

	// Chain of stage cells; stage s pairs channel i with channel i + 2^s.
	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		for (genvar i = 0; i < MAX_CH; i++) begin : g_pair
			if (((i >> s) % 2) == 0) begin : g_lo
				if (i + (1 << s) < CHANNELS) begin : g_cell
					bfm_kernel u_kernel (
						.clk   (clk),
						.en_s1 (en[2*s]),
						.en_s2 (en[2*s+1]),
						.a     (ch[s][i]),
						.b     (ch[s][i + (1 << s)]),
						.sn    (sine_q[s]),
						.cs    (cosine_q[s]),
						.refl  (refl_q[s]),
						.a_out (ch[s+1][i]),
						.b_out (ch[s+1][i + (1 << s)])
					);
				end else begin : g_pass
					// Partner channel is absent: the low channel passes through unchanged.
					sample_t pass_s1, pass_s2;
					always_ff @(posedge clk) begin
						if (en[2*s]) begin
							pass_s1 <= ch[s][i];
						end
						if (en[2*s+1]) begin
							pass_s2 <= pass_s1;
						end
					end
					assign ch[s+1][i]            = pass_s2;
					assign ch[s+1][i + (1 << s)] = '0;
				end
			end
		end
	end

	assign frame_out.out_ch0 = ch[STAGES][0];
	assign frame_out.out_ch1 = ch[STAGES][1];
	assign frame_out.out_ch2 = ch[STAGES][2];
	assign frame_out.out_ch3 = ch[STAGES][3];
	assign frame_out.out_ch4 = ch[STAGES][4];
	assign frame_out.out_ch5 = ch[STAGES][5];
	assign frame_out.out_ch6 = ch[STAGES][6];
	assign frame_out.out_ch7 = ch[STAGES][7];

endmodule
`default_nettype wire

[src/bfm_kernel.sv]
// One butterfly cell: 2x2 rotation or reflection of a channel pair over two levels.
`default_nettype none
module bfm_kernel import bfm_pkg::*; (
	input  wire     clk,
	input  wire     en_s1,
	input  wire     en_s2,
	input  sample_t a,
	input  sample_t b,
	input  coef_t   sn,
	input  coef_t   cs,
	input  wire     refl,
	output sample_t a_out,
	output sample_t b_out
);

	prod_t   ca_s1, sb_s1, sa_s1, cb_s1;
	logic    refl_s1;
	sum_t    sum_a, sum_b;
	sample_t a_s2, b_s2;

	// Operands are sign-extended first so the product keeps its full width.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			ca_s1   <= prod_t'(cs) * prod_t'(a);
			sb_s1   <= prod_t'(sn) * prod_t'(b);
			sa_s1   <= prod_t'(sn) * prod_t'(a);
			cb_s1   <= prod_t'(cs) * prod_t'(b);
			refl_s1 <= refl;
		end
	end

	always_comb begin
		if (refl_s1) begin
			sum_a = sum_t'(ca_s1) + sum_t'(sb_s1);
			sum_b = sum_t'(sa_s1) - sum_t'(cb_s1);
		end else begin
			sum_a = sum_t'(ca_s1) - sum_t'(sb_s1);
			sum_b = sum_t'(sa_s1) + sum_t'(cb_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			a_s2 <= round_sat(sum_a);
			b_s2 <= round_sat(sum_b);
		end
	end

	assign a_out = a_s2;
	assign b_out = b_s2;

endmodule
`default_nettype wire

[src/bfm_checker.sv]
// Port-level checks for the mixer, attached to the top level by bind.
`default_nettype none
module bfm_checker import bfm_pkg::*; (
	input wire     clk,
	input wire     arst_n,
	input wire     in_valid,
	input wire     in_ready,
	input wire     out_valid,
	input wire     out_ready,
	input wire     cfg_valid,
	input wire     cfg_ready,
	input sample_t out_ch0,
	input sample_t out_ch7
);

	localparam int CNT_W = $clog2(LEVELS + 1);

	logic [CNT_W-1:0] occ_q;
	logic             in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items accepted and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_acc && !out_acc) begin
			occ_q <= occ_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			occ_q <= occ_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_ch0) && $stable(out_ch7))
		else $error("output item changed while stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("output item without an accepted input item");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(LEVELS))
		else $error("more items in flight than pipeline levels");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == CNT_W'(LEVELS) && !out_ready |-> !in_ready)
		else $error("input item taken while pipeline full and stalled");

endmodule

bind butterfly_rotation_matrix_mix_unit bfm_checker u_bfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.out_ch0   (frame_out.out_ch0),
	.out_ch7   (frame_out.out_ch7)
);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the butterfly rotation mixer with a bit-true frame predictor.
`timescale 1ns / 1ps
module tb_top;
	import bfm_pkg::*;

	// Index 7 has no register behind it, so writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 14;
	localparam int PHASE_FRAMES   = 120;

	localparam sample_t S_MAX       = 16'sh7fff;
	localparam sample_t S_MIN       = 16'sh8000;
	localparam coef_t   C_MAX       = 16'sh7fff;
	localparam coef_t   C_MINUS_ONE = 16'sh8000;
	localparam coef_t   C_HALF      = 16'sh4000;

	typedef logic [MAX_CH-1:0][SAMPLE_BITS-1:0] frame_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bfm_in_if  frame_in();
	bfm_out_if frame_out();
	bfm_cfg_if cfg();

	// Predictor copy of the coefficient registers.
	coef_t                 stage_sine [NUM_STAGES];
	coef_t                 stage_cosine [NUM_STAGES];
	logic [NUM_STAGES-1:0] reflect_bits;

	frame_t mixed_q[$];
	bit     idle_on;
	int     mismatches   = 0;
	int     quiet_cycles = 0;

	butterfly_rotation_matrix_mix_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_in (frame_in),
		.frame_out(frame_out),
		.cfg      (cfg)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint round_clamp(input longint acc);
		longint q;
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -(longint'(1) <<< (SAMPLE_BITS - 1));
		// Adding half and shifting arithmetically rounds ties toward plus infinity.
		q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		if (q > hi) begin
			q = hi;
		end
		if (q < lo) begin
			q = lo;
		end
		return q;
	endfunction

	function automatic frame_t mix_frame(input frame_t x);
		longint ch [MAX_CH];
		longint a;
		longint b;
		longint sn;
		longint cs;
		int     stride;
		frame_t y;
		for (int k = 0; k < MAX_CH; k++) begin
			ch[k] = (k < CHANNELS) ? longint'($signed(x[k])) : 0;
		end
		for (int s = 0; s < NUM_STAGES; s++) begin
			stride = 1 << s;
			sn     = stage_sine[s];
			cs     = stage_cosine[s];
			if (2 * stride <= CHANNELS) begin
				// A channel whose stage bit is clear is the lower member of its pair.
				for (int p = 0; p < MAX_CH; p++) begin
					if ((p & stride) == 0 && p + stride < CHANNELS) begin
						a = ch[p];
						b = ch[p + stride];
						if (reflect_bits[s]) begin
							ch[p]          = round_clamp(cs * a + sn * b);
							ch[p + stride] = round_clamp(sn * a - cs * b);
						end else begin
							ch[p]          = round_clamp(cs * a - sn * b);
							ch[p + stride] = round_clamp(sn * a + cs * b);
						end
					end
				end
			end
		end
		for (int k = 0; k < MAX_CH; k++) begin
			y[k] = (k < CHANNELS) ? ch[k][SAMPLE_BITS-1:0] : '0;
		end
		return y;
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		for (int k = 0; k < MAX_CH; k++) begin
			case ($urandom_range(0, 7))
				0: f[k] = S_MAX;
				1: f[k] = S_MIN;
				2: f[k] = '0;
				3: f[k] = SAMPLE_BITS'($urandom_range(0, 15)) - 16'd8;
				default: f[k] = SAMPLE_BITS'($urandom());
			endcase
		end
		return f;
	endfunction

	function automatic coef_t rand_coef();
		coef_t c;
		case ($urandom_range(0, 5))
			0: c = C_MAX;
			1: c = C_MINUS_ONE;
			2: c = '0;
			default: c = COEF_BITS'($urandom());
		endcase
		return c;
	endfunction

	task automatic send_frame(input frame_t f);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid <= 1'b1;
		{frame_in.in_ch7, frame_in.in_ch6, frame_in.in_ch5, frame_in.in_ch4,
			frame_in.in_ch3, frame_in.in_ch2, frame_in.in_ch1, frame_in.in_ch0} <= f;
		do @(posedge clk); while (!frame_in.ready);
		mixed_q.push_back(mix_frame(f));
	endtask

	// Stops sending and waits until every mixed frame has come back out.
	task automatic settle();
		frame_in.valid <= 1'b0;
		while (mixed_q.size() != 0) @(posedge clk);
		repeat (LEVELS + 4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		if (idx < CFG_REFLECT) begin
			if (idx[0]) begin
				stage_cosine[idx >> 1] = data;
			end else begin
				stage_sine[idx >> 1] = data;
			end
		end else if (idx == CFG_REFLECT) begin
			reflect_bits = data[NUM_STAGES-1:0];
		end
	endtask

	task automatic write_regs(input coef_t s0, input coef_t c0, input coef_t s1, input coef_t c1,
		input coef_t s2, input coef_t c2, input logic [CFG_DATA_W-1:0] mask_word);
		settle();
		cfg_write(CFG_S0_SINE, s0);
		cfg_write(CFG_S0_COSINE, c0);
		cfg_write(CFG_S1_SINE, s1);
		cfg_write(CFG_S1_COSINE, c1);
		cfg_write(CFG_S2_SINE, s2);
		cfg_write(CFG_S2_COSINE, c2);
		cfg_write(CFG_REFLECT, mask_word);
		cfg_write(CFG_SPARE, CFG_DATA_W'($urandom()));
		cfg.valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_frame('0);
		send_frame({MAX_CH{S_MAX}});
		send_frame({MAX_CH{S_MIN}});
		send_frame({4{S_MIN, S_MAX}});
		send_frame({4{S_MAX, S_MIN}});
		send_frame({{(MAX_CH-1){16'sd0}}, 16'sd1});
	endtask

	// A cosine of one half with zero sine puts many sums exactly on a rounding tie.
	task automatic test_rounding_ties();
		write_regs('0, C_HALF, '0, C_HALF, '0, C_HALF, '0);
		send_frame({4{-16'sd1, 16'sd1}});
		send_frame({4{-16'sd3, 16'sd3}});
		send_frame({4{16'sd5, -16'sd5}});
		write_regs('0, C_HALF, '0, C_HALF, '0, C_HALF, 16'hfff8 | 16'd7);
		send_frame({4{-16'sd1, 16'sd1}});
		send_frame({4{16'sd3, -16'sd3}});
	endtask

	// Minus one times the most negative sample overflows and has to saturate.
	task automatic test_minus_one();
		write_regs(C_MINUS_ONE, C_MINUS_ONE, C_MAX, C_MINUS_ONE, C_MINUS_ONE, C_MAX, 16'd5);
		send_frame({MAX_CH{S_MIN}});
		send_frame({MAX_CH{S_MAX}});
		send_frame({4{S_MAX, S_MIN}});
		send_frame(rand_frame());
	endtask

	task automatic test_reflect_modes();
		for (int m = 0; m < 8; m++) begin
			write_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				CFG_DATA_W'(m));
			send_frame(rand_frame());
		end
	endtask

	task automatic test_random();
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_on = (phase % 3) != 2;
			if (phase == 0) begin
				write_regs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 16'hffff);
			end else if (phase == 1) begin
				write_regs(C_MINUS_ONE, C_MINUS_ONE, C_MINUS_ONE, C_MINUS_ONE, C_MINUS_ONE,
					C_MINUS_ONE, 16'h0000);
			end else begin
				write_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), CFG_DATA_W'($urandom()));
			end
			for (int n = 0; n < PHASE_FRAMES; n++) begin
				send_frame(rand_frame());
			end
		end
		settle();
	endtask

	initial begin
		frame_in.valid <= 1'b0;
		{frame_in.in_ch7, frame_in.in_ch6, frame_in.in_ch5, frame_in.in_ch4,
			frame_in.in_ch3, frame_in.in_ch2, frame_in.in_ch1, frame_in.in_ch0} <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data  <= '0;
		idle_on = 1'b1;
		for (int s = 0; s < NUM_STAGES; s++) begin
			stage_sine[s]   = 16'sd23170;
			stage_cosine[s] = 16'sd23170;
		end
		reflect_bits = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_rounding_ties();
		test_minus_one();
		test_reflect_modes();
		test_random();
		if (mismatches == 0 && mixed_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Result side: while idle_on is set, drops ready for a random stall before taking each item.
	initial begin : result_sink
		int stall;
		frame_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (stall != 0) begin
				frame_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_out.ready <= 1'b1;
			do @(posedge clk); while (!(frame_out.valid && frame_out.ready));
		end
	end

	always @(posedge clk) begin : result_check
		frame_t want;
		frame_t got;
		if (arst_n && frame_out.valid && frame_out.ready) begin
			got = {frame_out.out_ch7, frame_out.out_ch6, frame_out.out_ch5, frame_out.out_ch4,
				frame_out.out_ch3, frame_out.out_ch2, frame_out.out_ch1, frame_out.out_ch0};
			if (mixed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected output item %h", got);
				end
			end else begin
				want = mixed_q.pop_front();
				for (int k = 0; k < MAX_CH; k++) begin
					if (got[k] !== want[k]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("out_ch%0d: expected %0d, got %0d", k, $signed(want[k]),
								$signed(got[k]));
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (frame_in.valid && frame_in.ready) || (frame_out.valid && frame_out.ready)
			|| (cfg.valid && cfg.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end
	end

endmodule
